// File: sv/rsi_pkg.sv
// Shared types and constants for the relative strength index block.
// Used by every module of the block; depends on nothing.
package rsi_pkg;

    // Field widths
    localparam int PRICE_W   = 32;
    localparam int STAMP_W   = 32;
    localparam int RSI_W     = 23;
    localparam int PERIOD_W  = 7;
    localparam int FRAC_BITS = 16;

    // Average gain/loss: integer price part plus fraction bits
    localparam int AVG_W  = PRICE_W + FRAC_BITS;
    // Warm-up sum of up to 2**PERIOD_W - 1 differences
    localparam int SUM_W  = PRICE_W + PERIOD_W;
    // Average times (period - 1)
    localparam int PROD_W = AVG_W + PERIOD_W;

    // Long divider: quotient bits retired per cycle and cycles per division
    localparam int DIV_STEPS  = 4;
    localparam int DIV_BITS   = (PROD_W > SUM_W + FRAC_BITS) ? PROD_W : SUM_W + FRAC_BITS;
    localparam int DIV_CYCLES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_NUM_W  = DIV_CYCLES * DIV_STEPS;

    // Period register
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(64);

    // RSI scale: 100 in fixed point, and the value for flat series
    localparam logic [RSI_W-1:0] RSI_SCALE = RSI_W'(100 << FRAC_BITS);
    localparam logic [RSI_W-1:0] RSI_HALF  = RSI_W'(50 << FRAC_BITS);

    // Which average a smoothing pass works on
    localparam logic SIDE_GAIN = 1'b0;
    localparam logic SIDE_LOSS = 1'b1;

    typedef struct packed {
        logic               first_of_series;
        logic [PRICE_W-1:0] close_price;
        logic [STAMP_W-1:0] time_stamp;
    } rsi_in_t;

    typedef struct packed {
        logic [RSI_W-1:0]   rsi_value;
        logic               rsi_valid;
        logic [STAMP_W-1:0] out_time;
    } rsi_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic restart;
        logic accum;
        logic advance;
        logic mul;
        logic div_start;
        logic div_store;
        logic ratio_start;
        logic emit;
        logic side;
        logic smooth;
        logic emit_valid;
    } rsi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic restart;
        logic warm;
        logic seed;
        logic div_done;
        logic ratio_done;
        logic out_free;
    } rsi_stat_t;

endpackage

// File: sv/relative_strength_index.sv
// Top level of the Wilder relative strength index block.
// Depends on rsi_pkg, rsi_ctrl and rsi_dp.
//
//   channel   valid         stall          payload               dir
//   quote     quote_valid   quote_stall    quote  (rsi_in_t)     in
//   result    result_valid  result_stall   result (rsi_out_t)    out
//   period    period_we     -              period_data (7 bits)  in
//
// One beat at a time. A restarting or warm-up beat goes load, decide, emit;
// the seeding beat adds two passes of the shared long divider (start,
// 14 steps of 4 quotient bits, done) and the ratio unit (start, 23 scale
// bits one a cycle, done), and every later beat adds one multiply step per
// side before each divider pass.
// rst_n clears the period to 14 and the series state; no clearing pass.
// A finished result waits in the output register while the next quote beat
// is taken; only the emit step waits for result_stall to drop.
module relative_strength_index
    import rsi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quote_valid,
    output logic                quote_stall,
    input  rsi_in_t             quote,
    input  logic                period_we,
    input  logic [PERIOD_W-1:0] period_data,
    output logic                result_valid,
    input  logic                result_stall,
    output rsi_out_t            result
);

    rsi_cmd_t  cmd;
    rsi_stat_t stat;

    rsi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .quote_valid (quote_valid),
        .quote_stall (quote_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    rsi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .quote        (quote),
        .period_we    (period_we),
        .period_data  (period_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // An invalid result carries all-zero fields
    a_blank_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.rsi_valid |-> result.rsi_value == '0 && result.out_time == '0)
        else $error("invalid result with nonzero fields");

    // A valid RSI never exceeds 100
    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rsi_valid |-> result.rsi_value <= RSI_SCALE)
        else $error("rsi_value above full scale");

    // Once a quote beat is taken the block works on it before taking another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        quote_valid && !quote_stall |=> quote_stall)
        else $error("second quote beat taken back to back");
`endif

endmodule

// File: sv/rsi_div.sv
// Long divider for the average updates: wide numerator, period-sized divisor,
// DIV_STEPS quotient bits per cycle. Depends on rsi_pkg.
module rsi_div
    import rsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] numer,
    input  logic [PERIOD_W-1:0]  divisor,
    output logic                 done,
    output logic [AVG_W-1:0]     quot
);

    localparam int CYC_W = $clog2(DIV_CYCLES);

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [CYC_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Retire DIV_STEPS quotient bits; quotient bits shift in at the bottom
    always_comb
    begin : div_step
        logic [PERIOD_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial    = {rem_next, num_next[DIV_NUM_W-1]};
            num_next = {num_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next    = PERIOD_W'(trial - {1'b0, divisor});
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[PERIOD_W-1:0];
            end
        end
    end

    // Sequence the division
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CYC_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Hold numerator/quotient and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg[AVG_W-1:0];

endmodule

// File: sv/rsi_ratio.sv
// Exact ratio unit: floor(RSI_SCALE * G / (G + L)), one scale bit per cycle.
// Depends on rsi_pkg.
module rsi_ratio
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AVG_W-1:0] gain_avg,
    input  logic [AVG_W-1:0] loss_avg,
    output logic             done,
    output logic [RSI_W-1:0] value
);

    localparam int BIT_W = $clog2(RSI_W);
    localparam int T_W   = AVG_W + 3;

    logic [AVG_W-1:0] g_reg;
    logic [AVG_W:0]   s_reg;
    logic [AVG_W:0]   r_reg, r_next;
    logic [RSI_W-1:0] q_reg, q_next;
    logic [BIT_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;

    // Double the remainder, add G on set scale bits, take out up to 2*S
    always_comb
    begin : ratio_step
        logic [T_W-1:0] t;
        logic [T_W-1:0] s1;
        logic [T_W-1:0] s2;
        logic [1:0]     qinc;
        t  = {1'b0, r_reg, 1'b0}
           + (RSI_SCALE[bit_reg] ? {3'b000, g_reg} : {T_W{1'b0}});
        s1 = {2'b00, s_reg};
        s2 = {1'b0, s_reg, 1'b0};
        priority if (t >= s2)
        begin
            r_next = (AVG_W + 1)'(t - s2);
            qinc   = 2'd2;
        end
        else if (t >= s1)
        begin
            r_next = (AVG_W + 1)'(t - s1);
            qinc   = 2'd1;
        end
        else
        begin
            r_next = t[AVG_W:0];
            qinc   = 2'd0;
        end
        q_next = RSI_W'({q_reg, 1'b0} + {{(RSI_W - 1){1'b0}}, qinc});
    end

    // Sequence the scale bits, most significant first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operands, remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            g_reg   <= gain_avg;
            s_reg   <= {1'b0, gain_avg} + {1'b0, loss_avg};
            r_reg   <= '0;
            q_reg   <= '0;
            bit_reg <= BIT_W'(RSI_W - 1);
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            bit_reg <= bit_reg - 1'b1;
        end
    end

    assign done  = done_reg;
    // Both averages zero: report the midpoint
    assign value = (s_reg == '0) ? RSI_HALF : q_reg;

endmodule

// File: sv/rsi_dp.sv
// Datapath: series state, period register, multiplier, output register,
// and the divider and ratio units. Depends on rsi_pkg, rsi_div, rsi_ratio.
module rsi_dp
    import rsi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsi_cmd_t            cmd,
    output rsi_stat_t           stat,
    input  rsi_in_t             quote,
    input  logic                period_we,
    input  logic [PERIOD_W-1:0] period_data,
    output logic                result_valid,
    input  logic                result_stall,
    output rsi_out_t            result
);

    logic [PERIOD_W-1:0] period_reg;
    logic [PRICE_W-1:0]  prev_price_reg;
    logic                have_prev_reg;
    logic [PERIOD_W-1:0] count_reg;
    logic [AVG_W-1:0]    avg_gain_reg;
    logic [AVG_W-1:0]    avg_loss_reg;

    logic                first_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [PRICE_W-1:0]  gain_reg;
    logic [PRICE_W-1:0]  loss_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic                out_valid_reg;
    rsi_out_t            out_data_reg;

    logic [PERIOD_W-1:0]  period_clamped;
    logic [PERIOD_W-1:0]  period_m1;
    logic [AVG_W-1:0]     side_avg;
    logic [PRICE_W-1:0]   side_diff;
    logic [PROD_W-1:0]    prod_c;
    logic [DIV_NUM_W-1:0] div_numer;
    logic                 div_done;
    logic [AVG_W-1:0]     div_quot;
    logic                 ratio_done;
    logic [RSI_W-1:0]     ratio_value;

    // Clamp a period write into the legal range
    always_comb
    begin
        priority if (period_data < PERIOD_MIN)
            period_clamped = PERIOD_MIN;
        else if (period_data > PERIOD_MAX)
            period_clamped = PERIOD_MAX;
        else
            period_clamped = period_data;
    end

    assign period_m1 = period_reg - 1'b1;
    assign side_avg  = (cmd.side == SIDE_LOSS) ? avg_loss_reg : avg_gain_reg;
    assign side_diff = (cmd.side == SIDE_LOSS) ? loss_reg : gain_reg;
    assign prod_c    = PROD_W'(side_avg) * PROD_W'(period_m1);

    // Seed divides the raw sum; smoothing divides avg*(p-1) + diff
    assign div_numer = cmd.smooth
        ? DIV_NUM_W'(prod_reg) + DIV_NUM_W'({side_diff, {FRAC_BITS{1'b0}}})
        : DIV_NUM_W'({side_avg[SUM_W-1:0], {FRAC_BITS{1'b0}}});

    // Series state and period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            prev_price_reg <= '0;
            have_prev_reg  <= 1'b0;
            count_reg      <= '0;
            avg_gain_reg   <= '0;
            avg_loss_reg   <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                prev_price_reg <= price_reg;
                have_prev_reg  <= 1'b1;
                count_reg      <= '0;
                avg_gain_reg   <= '0;
                avg_loss_reg   <= '0;
            end
            if (cmd.accum)
            begin
                avg_gain_reg <= avg_gain_reg + AVG_W'(gain_reg);
                avg_loss_reg <= avg_loss_reg + AVG_W'(loss_reg);
                count_reg    <= count_reg + 1'b1;
            end
            if (cmd.advance)
                prev_price_reg <= price_reg;
            if (cmd.div_store)
            begin
                if (cmd.side == SIDE_LOSS)
                    avg_loss_reg <= div_quot;
                else
                    avg_gain_reg <= div_quot;
            end
            // A new period restarts warm-up
            if (period_we)
            begin
                period_reg    <= period_clamped;
                have_prev_reg <= 1'b0;
            end
        end
    end

    // Capture the beat and its price difference; hold the product
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg <= quote.first_of_series;
            price_reg <= quote.close_price;
            stamp_reg <= quote.time_stamp;
            if (quote.close_price > prev_price_reg)
            begin
                gain_reg <= quote.close_price - prev_price_reg;
                loss_reg <= '0;
            end
            else
            begin
                gain_reg <= '0;
                loss_reg <= prev_price_reg - quote.close_price;
            end
        end
        if (cmd.mul)
            prod_reg <= prod_c;
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.emit_valid)
            begin
                out_data_reg.rsi_value <= ratio_value;
                out_data_reg.rsi_valid <= 1'b1;
                out_data_reg.out_time  <= stamp_reg;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    rsi_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .numer   (div_numer),
        .divisor (period_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    rsi_ratio u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.ratio_start),
        .gain_avg (avg_gain_reg),
        .loss_avg (avg_loss_reg),
        .done     (ratio_done),
        .value    (ratio_value)
    );

    // Status to the controller
    assign stat.restart    = first_reg | ~have_prev_reg;
    assign stat.warm       = count_reg < period_reg;
    assign stat.seed       = ({1'b0, count_reg} + 1'b1) == {1'b0, period_reg};
    assign stat.div_done   = div_done;
    assign stat.ratio_done = ratio_done;
    assign stat.out_free   = ~out_valid_reg | ~result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// File: sv/rsi_ctrl.sv
// Controller: sequences one beat through classify, then multiply, divide and
// ratio as the beat needs, and emit. Depends on rsi_pkg.
module rsi_ctrl
    import rsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      quote_valid,
    output logic      quote_stall,
    input  rsi_stat_t stat,
    output rsi_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RATIO_START,
        ST_RATIO_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   side_reg, side_next;
    logic   smooth_reg, smooth_next;
    logic   valid_reg, valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        smooth_next    = smooth_reg;
        valid_next     = valid_reg;
        cmd            = '0;
        cmd.side       = side_reg;
        cmd.smooth     = smooth_reg;
        cmd.emit_valid = valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (quote_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                side_next   = SIDE_GAIN;
                smooth_next = 1'b0;
                valid_next  = 1'b0;
                priority if (stat.restart)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ST_EMIT;
                end
                else if (stat.warm)
                begin
                    cmd.accum   = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = stat.seed ? ST_DIV_START : ST_EMIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    smooth_next = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (side_reg == SIDE_GAIN)
                    begin
                        side_next  = SIDE_LOSS;
                        state_next = smooth_reg ? ST_MUL : ST_DIV_START;
                    end
                    else
                    begin
                        state_next = ST_RATIO_START;
                    end
                end
            end
            ST_RATIO_START:
            begin
                cmd.ratio_start = 1'b1;
                state_next      = ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT:
            begin
                if (stat.ratio_done)
                begin
                    valid_next = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            side_reg   <= SIDE_GAIN;
            smooth_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            side_reg   <= side_next;
            smooth_reg <= smooth_next;
            valid_reg  <= valid_next;
        end
    end

    assign quote_stall = (state_reg != ST_IDLE);

endmodule
